@@ design/lfu_cache_lru_tiebreak_macros.svh @@
// Assertion macros shared by the cache modules.
// LFU_ASSERT_IMPL checks the consequent in the same cycle as the antecedent.
// LFU_ASSERT_NEXT checks the consequent in the cycle after the antecedent.
`ifndef LFU_CACHE_LRU_TIEBREAK_MACROS_SVH
`define LFU_CACHE_LRU_TIEBREAK_MACROS_SVH

`ifndef SYNTHESIS

`define LFU_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("lfu cache: same-cycle check failed");

`define LFU_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("lfu cache: next-cycle check failed");

`else

`define LFU_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define LFU_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

@@ design/lfu_pkg.sv @@
package lfu_pkg;

    // Default sizing of the cache.
    localparam int CAPACITY_MAX_DEF = 16;
    localparam int COUNT_BITS_DEF   = 16;

    // Fixed field widths.
    localparam int DATA_W = 32;
    localparam int CAP_W  = 5;

    // Capacity register reset value.
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // Configuration port.
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic [APB_ADDR_W-1:0] ADDR_CAPACITY = 3'd0;

    // Action codes.
    localparam logic ACT_GET = 1'b0;
    localparam logic ACT_PUT = 1'b1;

    // Value returned by a get that misses.
    localparam logic [DATA_W-1:0] GET_MISS_VALUE = 32'hFFFF_FFFF;

    // One result word.
    typedef struct packed {
        logic              hit;
        logic [DATA_W-1:0] read_value;
        logic              evicted;
        logic [DATA_W-1:0] evicted_key;
    } lfu_result_t;

endpackage

@@ design/lfu_apb.sv @@
module lfu_apb import lfu_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic [CAP_W-1:0]      capacity
);

    logic [CAP_W-1:0] capacity_reg;
    logic [CAP_W-1:0] capacity_next;
    logic             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    // Register write decode.
    always_comb begin
        capacity_next = capacity_reg;
        if (wr_en && (paddr == ADDR_CAPACITY)) begin
            capacity_next = pwdata[CAP_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= CAP_RESET;
        end else begin
            capacity_reg <= capacity_next;
        end
    end

    // Read back; unmapped addresses read as zero.
    always_comb begin
        prdata = '0;
        if (paddr == ADDR_CAPACITY) begin
            prdata = {{(APB_DATA_W-CAP_W){1'b0}}, capacity_reg};
        end
    end

    assign capacity = capacity_reg;

endmodule

@@ design/lfu_search.sv @@
module lfu_search import lfu_pkg::*; #(
    parameter int CAPACITY_MAX = CAPACITY_MAX_DEF,
    parameter int COUNT_BITS   = COUNT_BITS_DEF,
    localparam int IDX_W       = (CAPACITY_MAX > 1) ? $clog2(CAPACITY_MAX) : 1
) (
    input  logic [CAPACITY_MAX-1:0] slot_valid,
    input  logic [DATA_W-1:0]       slot_key   [CAPACITY_MAX],
    input  logic [COUNT_BITS-1:0]   slot_count [CAPACITY_MAX],
    input  logic [IDX_W-1:0]        slot_rank  [CAPACITY_MAX],
    input  logic [DATA_W-1:0]       key,
    output logic                    match_hit,
    output logic [IDX_W-1:0]        match_idx,
    output logic [IDX_W-1:0]        victim_idx,
    output logic [IDX_W-1:0]        free_idx
);

    localparam int LEAVES = 1 << IDX_W;

    logic                  node_valid [1:2*LEAVES-1];
    logic [COUNT_BITS-1:0] node_count [1:2*LEAVES-1];
    logic [IDX_W-1:0]      node_rank  [1:2*LEAVES-1];
    logic [IDX_W-1:0]      node_idx   [1:2*LEAVES-1];

    // Key match; the lowest matching slot wins.
    always_comb begin
        match_hit = 1'b0;
        match_idx = '0;
        for (int i = CAPACITY_MAX - 1; i >= 0; i--) begin
            if (slot_valid[i] && (slot_key[i] == key)) begin
                match_hit = 1'b1;
                match_idx = IDX_W'(i);
            end
        end
    end

    // First empty slot.
    always_comb begin
        free_idx = '0;
        for (int i = CAPACITY_MAX - 1; i >= 0; i--) begin
            if (!slot_valid[i]) begin
                free_idx = IDX_W'(i);
            end
        end
    end

    // Victim tree: lowest use count, and among equal counts the oldest entry.
    // Leaves beyond the slot count are empty.
    always_comb begin
        logic take_right;
        for (int i = 0; i < LEAVES; i++) begin
            if (i < CAPACITY_MAX) begin
                node_valid[LEAVES+i] = slot_valid[i];
                node_count[LEAVES+i] = slot_count[i];
                node_rank[LEAVES+i]  = slot_rank[i];
            end else begin
                node_valid[LEAVES+i] = 1'b0;
                node_count[LEAVES+i] = '0;
                node_rank[LEAVES+i]  = '0;
            end
            node_idx[LEAVES+i] = IDX_W'(i);
        end
        for (int n = LEAVES - 1; n >= 1; n--) begin
            take_right = !node_valid[2*n] ||
                         (node_valid[2*n+1] &&
                          ((node_count[2*n+1] < node_count[2*n]) ||
                           ((node_count[2*n+1] == node_count[2*n]) &&
                            (node_rank[2*n+1] > node_rank[2*n]))));
            if (take_right) begin
                node_valid[n] = node_valid[2*n+1];
                node_count[n] = node_count[2*n+1];
                node_rank[n]  = node_rank[2*n+1];
                node_idx[n]   = node_idx[2*n+1];
            end else begin
                node_valid[n] = node_valid[2*n];
                node_count[n] = node_count[2*n];
                node_rank[n]  = node_rank[2*n];
                node_idx[n]   = node_idx[2*n];
            end
        end
        victim_idx = node_idx[1];
    end

endmodule

@@ design/lfu_store.sv @@
`include "lfu_cache_lru_tiebreak_macros.svh"

module lfu_store import lfu_pkg::*; #(
    parameter int CAPACITY_MAX = CAPACITY_MAX_DEF,
    parameter int COUNT_BITS   = COUNT_BITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,
    input  logic              action,
    input  logic [DATA_W-1:0] key,
    input  logic [DATA_W-1:0] value,
    input  logic [CAP_W-1:0]  capacity,
    output lfu_result_t       result
);

    localparam int IDX_W = (CAPACITY_MAX > 1) ? $clog2(CAPACITY_MAX) : 1;
    localparam int OCC_W = $clog2(CAPACITY_MAX + 1);
    localparam int CMP_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;

    logic [CAPACITY_MAX-1:0] valid_reg;
    logic [CAPACITY_MAX-1:0] valid_next;
    logic [DATA_W-1:0]       key_reg    [CAPACITY_MAX];
    logic [DATA_W-1:0]       key_next   [CAPACITY_MAX];
    logic [DATA_W-1:0]       value_reg  [CAPACITY_MAX];
    logic [DATA_W-1:0]       value_next [CAPACITY_MAX];
    logic [COUNT_BITS-1:0]   count_reg  [CAPACITY_MAX];
    logic [COUNT_BITS-1:0]   count_next [CAPACITY_MAX];
    logic [IDX_W-1:0]        rank_reg   [CAPACITY_MAX];
    logic [IDX_W-1:0]        rank_next  [CAPACITY_MAX];
    logic [OCC_W-1:0]        occ_reg;
    logic [OCC_W-1:0]        occ_next;

    logic             match_hit;
    logic [IDX_W-1:0] match_idx;
    logic [IDX_W-1:0] victim_idx;
    logic [IDX_W-1:0] free_idx;

    logic [CMP_W-1:0] cap_eff;
    logic             cap_zero;
    logic             full;
    logic             is_put;
    logic             touch;
    logic             insert_free;
    logic [IDX_W-1:0] tgt;
    logic [OCC_W-1:0] age_limit;

    lfu_search #(
        .CAPACITY_MAX (CAPACITY_MAX),
        .COUNT_BITS   (COUNT_BITS)
    ) u_search (
        .slot_valid (valid_reg),
        .slot_key   (key_reg),
        .slot_count (count_reg),
        .slot_rank  (rank_reg),
        .key        (key),
        .match_hit  (match_hit),
        .match_idx  (match_idx),
        .victim_idx (victim_idx),
        .free_idx   (free_idx)
    );

    // Effective capacity, clamped to the number of slots.
    assign cap_eff = (CMP_W'(capacity) > CMP_W'(CAPACITY_MAX)) ?
                     CMP_W'(CAPACITY_MAX) : CMP_W'(capacity);
    assign cap_zero = (cap_eff == '0);
    assign full     = (CMP_W'(occ_reg) >= cap_eff);
    assign is_put   = (action == ACT_PUT);

    // A get touches the entry only on a hit; a put touches a slot unless disabled.
    assign touch       = step && (is_put ? !cap_zero : match_hit);
    assign insert_free = is_put && !match_hit && !full;
    assign tgt         = match_hit ? match_idx : (full ? victim_idx : free_idx);
    assign age_limit   = insert_free ? occ_reg : OCC_W'(rank_reg[tgt]);

    // Slot update: the touched slot becomes the most recent, younger entries age.
    always_comb begin
        valid_next = valid_reg;
        key_next   = key_reg;
        value_next = value_reg;
        count_next = count_reg;
        rank_next  = rank_reg;
        occ_next   = occ_reg;
        if (touch) begin
            for (int i = 0; i < CAPACITY_MAX; i++) begin
                if ((IDX_W'(i) != tgt) && valid_reg[i] &&
                    (OCC_W'(rank_reg[i]) < age_limit)) begin
                    rank_next[i] = rank_reg[i] + 1'b1;
                end
            end
            rank_next[tgt] = '0;
            if (match_hit) begin
                if (count_reg[tgt] != {COUNT_BITS{1'b1}}) begin
                    count_next[tgt] = count_reg[tgt] + 1'b1;
                end
            end else begin
                count_next[tgt] = COUNT_BITS'(1);
                key_next[tgt]   = key;
            end
            if (is_put) begin
                value_next[tgt] = value;
            end
            if (insert_free) begin
                valid_next[tgt] = 1'b1;
                occ_next        = occ_reg + 1'b1;
            end
        end
    end

    // Result fields.
    always_comb begin
        result.hit         = match_hit;
        result.read_value  = '0;
        result.evicted     = 1'b0;
        result.evicted_key = '0;
        if (!is_put) begin
            result.read_value = match_hit ? value_reg[match_idx] : GET_MISS_VALUE;
        end else if (!cap_zero && !match_hit && full) begin
            result.evicted     = 1'b1;
            result.evicted_key = key_reg[victim_idx];
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            occ_reg   <= '0;
        end else begin
            valid_reg <= valid_next;
            occ_reg   <= occ_next;
        end
    end

    // Slot contents.
    always_ff @(posedge aclk) begin
        key_reg   <= key_next;
        value_reg <= value_next;
        count_reg <= count_next;
        rank_reg  <= rank_next;
    end

    // The fill count always equals the number of occupied slots.
    `LFU_ASSERT_IMPL(a_occ_tracks_valid, aclk, aresetn, 1'b1, occ_reg == $countones(valid_reg))
    // An eviction reuses the victim's slot, so occupancy is unchanged.
    `LFU_ASSERT_NEXT(a_evict_keeps_occ, aclk, aresetn, step && result.evicted, $stable(occ_reg))
    // A lookup never adds or removes entries.
    `LFU_ASSERT_NEXT(a_get_keeps_valid, aclk, aresetn, step && (action == ACT_GET), $stable(valid_reg))

endmodule

@@ design/lfu_cache_lru_tiebreak.sv @@
// Channel   Direction  Handshake          Payload
// s_        in         s_tvalid/s_tready  s_tuser: action; s_tdata: key, value
// m_        out        m_tvalid/m_tready  m_tuser: hit, evicted; m_tdata: read_value, evicted_key
// cfg       in         psel/penable       capacity at byte address 0
//
// One word is taken per cycle while s_tready is high; it passes through the input word
// register and then the result register, from which its result is presented on m_.
// The lookup, the victim search and the slot update all fit between the input
// word register and the result register, so throughput is one word per cycle unless m_ stalls.
// Reset is synchronous and active low; it empties the cache and sets capacity to 16.
// When a result is stalled, the input register holds one further word and then stalls.
`include "lfu_cache_lru_tiebreak_macros.svh"

module lfu_cache_lru_tiebreak import lfu_pkg::*; #(
    parameter int CAPACITY_MAX = CAPACITY_MAX_DEF,
    parameter int COUNT_BITS   = COUNT_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Input words
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [2*DATA_W-1:0]   s_tdata,   // [31:0] key, [63:32] value
    input  logic                  s_tuser,   // [0] action
    // Result words
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [2*DATA_W-1:0]   m_tdata,   // [31:0] read_value, [63:32] evicted_key
    output logic [1:0]            m_tuser,   // [0] hit, [1] evicted
    // Configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic              in_valid_reg;
    logic              in_valid_next;
    logic              action_reg;
    logic [DATA_W-1:0] key_reg;
    logic [DATA_W-1:0] value_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    lfu_result_t       out_data_reg;
    lfu_result_t       result;
    logic [CAP_W-1:0]  capacity;
    logic              step;

    lfu_apb u_apb (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .capacity (capacity)
    );

    lfu_store #(
        .CAPACITY_MAX (CAPACITY_MAX),
        .COUNT_BITS   (COUNT_BITS)
    ) u_store (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step     (step),
        .action   (action_reg),
        .key      (key_reg),
        .value    (value_reg),
        .capacity (capacity),
        .result   (result)
    );

    // A held word is processed whenever the result register is free or draining.
    assign step     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || step;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tready) begin
            in_valid_next = s_tvalid;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (step) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Input word register.
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            action_reg <= s_tuser;
            key_reg    <= s_tdata[DATA_W-1:0];
            value_reg  <= s_tdata[2*DATA_W-1:DATA_W];
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (step) begin
            out_data_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_data_reg.evicted_key, out_data_reg.read_value};
    assign m_tuser  = {out_data_reg.evicted, out_data_reg.hit};

    // A held word with a free result register always yields a result next cycle.
    `LFU_ASSERT_NEXT(a_step_fills_out, aclk, aresetn, in_valid_reg && !out_valid_reg, out_valid_reg)

endmodule
